// File: rtl/core/rpap_pkg.sv
// Package for the pivot rotation block: widths, register indexes, CORDIC table.
// No dependencies.
package rpap_pkg;
  localparam int CoordWidth = 24;
  localparam int AngleWidth = 16;
  localparam int CordicSteps = 24;
  localparam int TrigWidth = 16;
  localparam int RegCount = 6;
  localparam int AddrWidth = 5;

  localparam logic [2:0] RegAngleX = 3'd0;
  localparam logic [2:0] RegAngleY = 3'd1;
  localparam logic [2:0] RegAngleZ = 3'd2;
  localparam logic [2:0] RegPivotX = 3'd3;
  localparam logic [2:0] RegPivotY = 3'd4;
  localparam logic [2:0] RegPivotZ = 3'd5;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic signed [TrigWidth-1:0] sin_v;
    logic signed [TrigWidth-1:0] cos_v;
    logic enable;
  } axis_coef_t;

  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: atan_turn = 32'sd536870912;
      5'd1: atan_turn = 32'sd316933406;
      5'd2: atan_turn = 32'sd167458907;
      5'd3: atan_turn = 32'sd85004756;
      5'd4: atan_turn = 32'sd42667331;
      5'd5: atan_turn = 32'sd21354465;
      5'd6: atan_turn = 32'sd10679838;
      5'd7: atan_turn = 32'sd5340245;
      5'd8: atan_turn = 32'sd2670163;
      5'd9: atan_turn = 32'sd1335087;
      5'd10: atan_turn = 32'sd667544;
      5'd11: atan_turn = 32'sd333772;
      5'd12: atan_turn = 32'sd166886;
      5'd13: atan_turn = 32'sd83443;
      5'd14: atan_turn = 32'sd41722;
      5'd15: atan_turn = 32'sd20861;
      5'd16: atan_turn = 32'sd10430;
      5'd17: atan_turn = 32'sd5215;
      5'd18: atan_turn = 32'sd2608;
      5'd19: atan_turn = 32'sd1304;
      5'd20: atan_turn = 32'sd652;
      5'd21: atan_turn = 32'sd326;
      5'd22: atan_turn = 32'sd163;
      5'd23: atan_turn = 32'sd81;
      default: atan_turn = 32'sd0;
    endcase
  endfunction
endpackage

// File: rtl/core/rpap_trig.sv
// Sine/cosine unit: iterative CORDIC, one step per cycle, for one angle.
// Depends on rpap_pkg.
module rpap_trig #(
  parameter int ANGLE_WIDTH = rpap_pkg::AngleWidth
) (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output logic running,
  output rpap_pkg::axis_coef_t coef
);
  import rpap_pkg::*;

  logic busy;
  logic done_q;
  logic [4:0] step;
  logic [1:0] quad;
  logic signed [33:0] x, y, z;
  logic signed [33:0] x_next, y_next, z_next;
  logic [31:0] phase;
  logic signed [33:0] xr, yr;
  logic signed [TrigWidth-1:0] cr, sr;

  assign phase = 32'(angle) << (32 - ANGLE_WIDTH);
  assign running = busy || done_q;

  always_comb begin
    if (!z[33]) begin
      x_next = x - (y >>> step);
      y_next = y + (x >>> step);
      z_next = z - 34'(atan_turn(step));
    end else begin
      x_next = x + (y >>> step);
      y_next = y - (x >>> step);
      z_next = z + 34'(atan_turn(step));
    end
  end

  function automatic logic signed [TrigWidth-1:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) to_q15 = 16'sd32767;
    else if (r < -34'sd32767) to_q15 = -16'sd32767;
    else to_q15 = r[TrigWidth-1:0];
  endfunction

  assign xr = x;
  assign yr = y;
  assign cr = to_q15(xr);
  assign sr = to_q15(yr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
      step <= '0;
      coef.sin_v <= '0;
      coef.cos_v <= 16'sd32767;
      coef.enable <= 1'b0;
    end else begin
      done_q <= busy && (step == 5'(CordicSteps - 1)) && !load;
      if (load) begin
        busy <= 1'b1;
        step <= '0;
        quad <= phase[31:30];
        x <= CordicGain;
        y <= '0;
        z <= 34'(phase[29:0]);
        coef.enable <= (angle != '0);
      end else if (busy) begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        if (step == 5'(CordicSteps - 1)) begin
          busy <= 1'b0;
        end
        step <= step + 5'd1;
      end else begin
        step <= step;
      end
      if (done_q) begin
        case (quad)
          2'd0: begin coef.cos_v <= cr; coef.sin_v <= sr; end
          2'd1: begin coef.cos_v <= -sr; coef.sin_v <= cr; end
          2'd2: begin coef.cos_v <= -cr; coef.sin_v <= -sr; end
          default: begin coef.cos_v <= sr; coef.sin_v <= -cr; end
        endcase
      end
    end
  end
endmodule

// File: rtl/core/rpap_axis.sv
// One axis rotation: a multiply stage, a sum/round stage and a saturate (or bypass) stage.
// Depends on rpap_pkg.
module rpap_axis #(
  parameter int W = rpap_pkg::CoordWidth + 1
) (
  input  logic clk,
  input  logic rst,
  input  rpap_pkg::axis_coef_t coef,
  input  logic in_valid,
  input  logic signed [W-1:0] in_a,
  input  logic signed [W-1:0] in_b,
  input  logic signed [W-1:0] in_c,
  output logic out_valid,
  output logic signed [W-1:0] out_a,
  output logic signed [W-1:0] out_b,
  output logic signed [W-1:0] out_c
);
  import rpap_pkg::*;

  localparam int PW = W + TrigWidth + 2;
  localparam logic signed [PW-1:0] Hi = PW'({1'b0, {(W - 1){1'b1}}});
  localparam logic signed [PW-1:0] Lo = -Hi - PW'(1);

  logic v1, v2;
  logic en1, en2;
  logic signed [W-1:0] a1, b1, c1, a2, b2, c2;
  logic signed [PW-1:0] p_ca, p_sb, p_sa, p_cb;
  logic signed [PW-1:0] s_a, s_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    en1 <= coef.enable;
    a1 <= in_a;
    b1 <= in_b;
    c1 <= in_c;
    p_ca <= PW'(coef.cos_v) * PW'(in_a);
    p_sb <= PW'(coef.sin_v) * PW'(in_b);
    p_sa <= PW'(coef.sin_v) * PW'(in_a);
    p_cb <= PW'(coef.cos_v) * PW'(in_b);
    en2 <= en1;
    a2 <= a1;
    b2 <= b1;
    c2 <= c1;
    s_a <= (p_ca - p_sb + PW'(16384)) >>> 15;
    s_b <= (p_sa + p_cb + PW'(16384)) >>> 15;
    if (en2) begin
      out_a <= (s_a > Hi) ? Hi[W-1:0] : ((s_a < Lo) ? Lo[W-1:0] : s_a[W-1:0]);
      out_b <= (s_b > Hi) ? Hi[W-1:0] : ((s_b < Lo) ? Lo[W-1:0] : s_b[W-1:0]);
    end else begin
      out_a <= a2;
      out_b <= b2;
    end
    out_c <= c2;
  end
endmodule

// File: rtl/core/rotate_point_about_pivot.sv
// Rotate one 3D vertex about a configured pivot, X then Y then Z.
// Channels: start/busy command input, done strobe output, APB config port.
// Done comes out of these registered stages, in order: pivot subtract (1),
// three axis units (3 each: multiply, sum and round, saturate and bypass),
// pivot add with saturation (1).
// Throughput: one vertex per cycle while no sine/cosine update runs.
// An angle write starts a 24-step CORDIC for that axis; busy stays high from
// the write until the new sine and cosine are in place.
// Write configuration only while no vertex is in flight.
// Reset sets angles and pivots to 0, sine to 0, cosine to 32767, and clears
// the pipeline valid bits; the datapath registers are not reset.
// The receiver cannot stall: done is high for exactly one cycle per vertex.
// Depends on rpap_pkg, rpap_trig, rpap_axis.
module rotate_point_about_pivot #(
  parameter int COORD_WIDTH = rpap_pkg::CoordWidth,
  parameter int ANGLE_WIDTH = rpap_pkg::AngleWidth
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic done,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic signed [COORD_WIDTH-1:0] rotated_z,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [rpap_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import rpap_pkg::*;

  localparam int W = COORD_WIDTH + 1;
  localparam int SW = COORD_WIDTH + 2;
  localparam logic signed [SW-1:0] Hi = SW'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
  localparam logic signed [SW-1:0] Lo = -Hi - SW'(1);

  logic [ANGLE_WIDTH-1:0] angle_x, angle_y, angle_z;
  logic signed [COORD_WIDTH-1:0] piv_x, piv_y, piv_z;
  logic wr;
  logic [2:0] idx;
  logic run_x, run_y, run_z;
  axis_coef_t cx, cy, cz;

  assign pready = 1'b1;
  assign busy = run_x || run_y || run_z;
  assign wr = psel && penable && pwrite && pready;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x <= '0;
      angle_y <= '0;
      angle_z <= '0;
      piv_x <= '0;
      piv_y <= '0;
      piv_z <= '0;
    end else if (wr) begin
      case (idx)
        RegAngleX: angle_x <= pwdata[ANGLE_WIDTH-1:0];
        RegAngleY: angle_y <= pwdata[ANGLE_WIDTH-1:0];
        RegAngleZ: angle_z <= pwdata[ANGLE_WIDTH-1:0];
        RegPivotX: piv_x <= pwdata[COORD_WIDTH-1:0];
        RegPivotY: piv_y <= pwdata[COORD_WIDTH-1:0];
        RegPivotZ: piv_z <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegAngleX: prdata = 32'(angle_x);
      RegAngleY: prdata = 32'(angle_y);
      RegAngleZ: prdata = 32'(angle_z);
      RegPivotX: prdata = 32'(piv_x);
      RegPivotY: prdata = 32'(piv_y);
      RegPivotZ: prdata = 32'(piv_z);
      default: prdata = '0;
    endcase
  end

  logic ldx, ldy, ldz;
  assign ldx = wr && idx == RegAngleX;
  assign ldy = wr && idx == RegAngleY;
  assign ldz = wr && idx == RegAngleZ;

  rpap_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_x (
    .clk(clk), .rst(rst), .load(ldx), .angle(pwdata[ANGLE_WIDTH-1:0]),
    .running(run_x), .coef(cx));
  rpap_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_y (
    .clk(clk), .rst(rst), .load(ldy), .angle(pwdata[ANGLE_WIDTH-1:0]),
    .running(run_y), .coef(cy));
  rpap_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_z (
    .clk(clk), .rst(rst), .load(ldz), .angle(pwdata[ANGLE_WIDTH-1:0]),
    .running(run_z), .coef(cz));

  logic v0;
  logic signed [W-1:0] dx, dy, dz;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start && !busy;
    dx <= W'(point_x) - W'(piv_x);
    dy <= W'(point_y) - W'(piv_y);
    dz <= W'(point_z) - W'(piv_z);
  end

  // X axis: (y, z); Y axis: (z, x) with b=x a=z -> rotated as (x', z')
  logic v1, v2, v3;
  logic signed [W-1:0] y1, z1, x1, z2, x2, y2, x3, y3, z3;
  axis_coef_t cy_m;

  rpap_axis #(.W(W)) u_ax_x (
    .clk(clk), .rst(rst), .coef(cx), .in_valid(v0),
    .in_a(dy), .in_b(dz), .in_c(dx),
    .out_valid(v1), .out_a(y1), .out_b(z1), .out_c(x1));

  // Y: x' = c x + s z ; z' = -s x + c z  == axis form on (a=z, b=x)
  assign cy_m = cy;
  rpap_axis #(.W(W)) u_ax_y (
    .clk(clk), .rst(rst), .coef(cy_m), .in_valid(v1),
    .in_a(z1), .in_b(x1), .in_c(y1),
    .out_valid(v2), .out_a(z2), .out_b(x2), .out_c(y2));

  rpap_axis #(.W(W)) u_ax_z (
    .clk(clk), .rst(rst), .coef(cz), .in_valid(v2),
    .in_a(x2), .in_b(y2), .in_c(z2),
    .out_valid(v3), .out_a(x3), .out_b(y3), .out_c(z3));

  function automatic logic signed [COORD_WIDTH-1:0] sat_sum(
      input logic signed [W-1:0] a, input logic signed [COORD_WIDTH-1:0] p);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(p);
    if (s > Hi) sat_sum = Hi[COORD_WIDTH-1:0];
    else if (s < Lo) sat_sum = Lo[COORD_WIDTH-1:0];
    else sat_sum = s[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v3;
    rotated_x <= sat_sum(x3, piv_x);
    rotated_y <= sat_sum(y3, piv_y);
    rotated_z <= sat_sum(z3, piv_z);
  end
endmodule

// File: verif/rpap_checker.sv
// Checker for rotate_point_about_pivot: snoops APB writes, predicts each rotated
// vertex and compares it with the done word. Depends on rpap_pkg.
`timescale 1ns / 1ps
module rpap_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic signed [rpap_pkg::CoordWidth-1:0] point_x,
  input  logic signed [rpap_pkg::CoordWidth-1:0] point_y,
  input  logic signed [rpap_pkg::CoordWidth-1:0] point_z,
  input  logic done,
  input  logic signed [rpap_pkg::CoordWidth-1:0] rotated_x,
  input  logic signed [rpap_pkg::CoordWidth-1:0] rotated_y,
  input  logic signed [rpap_pkg::CoordWidth-1:0] rotated_z,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic pready,
  input  logic [rpap_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0] pwdata,
  output int errors,
  output int pending,
  output int vertices_in,
  output int vertices_out
);
  import rpap_pkg::*;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  localparam longint TurnStep [CordicSteps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  logic [AngleWidth-1:0] angle [3];
  longint pivot [3];
  longint sine [3];
  longint cosine [3];
  vertex_t rotated_q [$];

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    return r > 32767 ? 32767 : (r < -32767 ? -32767 : r);
  endfunction

  function automatic longint rot_term(longint c1, longint a, longint c2, longint b);
    return clamp((c1 * a + c2 * b + 16384) >>> 15, CoordWidth + 1);
  endfunction

  task automatic load_angle(int axis, logic [AngleWidth-1:0] ang);
    logic [31:0] phase;
    longint cx, cy, cz, nx, cr, sr;
    phase = {ang, {(32 - AngleWidth){1'b0}}};
    cz = longint'(phase[29:0]);
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz = cz - TurnStep[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz = cz + TurnStep[i];
      end
      cx = nx;
    end
    cr = round_q15(cx);
    sr = round_q15(cy);
    angle[axis] = ang;
    case (phase[31:30])
      2'd0: begin cosine[axis] = cr;  sine[axis] = sr;  end
      2'd1: begin cosine[axis] = -sr; sine[axis] = cr;  end
      2'd2: begin cosine[axis] = -cr; sine[axis] = -sr; end
      default: begin cosine[axis] = sr; sine[axis] = -cr; end
    endcase
  endtask

  function automatic vertex_t rotate_vertex(coord_t px, coord_t py, coord_t pz);
    longint x, y, z, t;
    vertex_t r;
    x = longint'(px) - pivot[0];
    y = longint'(py) - pivot[1];
    z = longint'(pz) - pivot[2];
    if (angle[0] != 0) begin
      t = rot_term(cosine[0], y, -sine[0], z);
      z = rot_term(sine[0], y, cosine[0], z);
      y = t;
    end
    if (angle[1] != 0) begin
      t = rot_term(cosine[1], x, sine[1], z);
      z = rot_term(-sine[1], x, cosine[1], z);
      x = t;
    end
    if (angle[2] != 0) begin
      t = rot_term(cosine[2], x, -sine[2], y);
      y = rot_term(sine[2], x, cosine[2], y);
      x = t;
    end
    r.x = coord_t'(clamp(x + pivot[0], CoordWidth));
    r.y = coord_t'(clamp(y + pivot[1], CoordWidth));
    r.z = coord_t'(clamp(z + pivot[2], CoordWidth));
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        angle[i] = '0;
        pivot[i] = 0;
        sine[i] = 0;
        cosine[i] = 32767;
      end
      rotated_q.delete();
      errors = 0;
      pending = 0;
      vertices_in = 0;
      vertices_out = 0;
    end else begin
      if (done) begin
        vertices_out++;
        if (rotated_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          want = rotated_q.pop_front();
          if (rotated_x !== want.x) report("rotated_x", rotated_x, want.x);
          if (rotated_y !== want.y) report("rotated_y", rotated_y, want.y);
          if (rotated_z !== want.z) report("rotated_z", rotated_z, want.z);
        end
      end
      if (start && !busy) begin
        vertices_in++;
        rotated_q = {rotated_q, rotate_vertex(point_x, point_y, point_z)};
      end
      if (psel && penable && pwrite && pready) begin
        case (3'(paddr >> 2))
          RegAngleX: load_angle(0, pwdata[AngleWidth-1:0]);
          RegAngleY: load_angle(1, pwdata[AngleWidth-1:0]);
          RegAngleZ: load_angle(2, pwdata[AngleWidth-1:0]);
          RegPivotX: pivot[0] = longint'(coord_t'(pwdata[CoordWidth-1:0]));
          RegPivotY: pivot[1] = longint'(coord_t'(pwdata[CoordWidth-1:0]));
          RegPivotZ: pivot[2] = longint'(coord_t'(pwdata[CoordWidth-1:0]));
          default: ;
        endcase
      end
      pending = rotated_q.size();
    end
  end
endmodule

// File: verif/tb_rotate_point_about_pivot.sv
// Testbench top for rotate_point_about_pivot: clock, reset, APB settings and
// vertex stimulus in bursts. Depends on rpap_pkg and rpap_checker.
`timescale 1ns / 1ps
module tb_rotate_point_about_pivot;
  import rpap_pkg::*;

  typedef logic signed [CoordWidth-1:0] coord_t;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam coord_t CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, pready;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  coord_t rotated_x, rotated_y, rotated_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  int errors, pending, vertices_in, vertices_out;
  int burst_left = 0;
  int settings_done = 0;

  always #10 clk = ~clk;

  rotate_point_about_pivot dut (.*);

  rpap_checker u_checker (.*);

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrWidth'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic apply_setting(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               coord_t vx, coord_t vy, coord_t vz);
    drain();
    reg_write(RegAngleX, 32'(ax));
    reg_write(RegAngleY, 32'(ay));
    reg_write(RegAngleZ, 32'(az));
    reg_write(RegPivotX, 32'(vx));
    reg_write(RegPivotY, 32'(vy));
    reg_write(RegPivotZ, 32'(vz));
    repeat (30) @(posedge clk);
    settings_done++;
  endtask

  task automatic send_vertex(coord_t x, coord_t y, coord_t z);
    int gap;
    start <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(0, 9))
      0: return CoordMax;
      1: return CoordMin;
      2, 3, 4: return coord_t'($urandom_range(0, 8191)) - coord_t'(4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] any_angle();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'(16'h4000 * $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_vertices(int n);
    for (int i = 0; i < n; i++) begin
      send_vertex(any_coord(), any_coord(), any_coord());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    send_vertex(CoordMax, CoordMin, '0);
    send_vertex(CoordMin, CoordMax, 24'sd1);
    send_vertex(-24'sd1, 24'sd256, CoordMax);

    drain();
    reg_write(RegUnused, 32'hFFFF_FFFF);
    apply_setting(16'hFFFF, 16'h0001, 16'h8000, CoordMax, CoordMin, '0);
    send_vertex(CoordMin, CoordMax, CoordMin);
    send_vertex(CoordMax, CoordMax, CoordMax);
    send_vertex(CoordMin, CoordMin, CoordMin);
    send_vertex('0, '0, '0);

    apply_setting(16'h4000, 16'hC000, 16'h2000, CoordMin, CoordMax, CoordMin);
    send_vertex(CoordMax, CoordMin, CoordMax);
    send_vertex(CoordMin, CoordMax, CoordMin);
    send_vertex(24'sd256, -24'sd256, 24'sd128);

    apply_setting(16'h0000, 16'h4000, 16'h0000, 24'sd1280, -24'sd512, 24'sd77);
    send_vertex(CoordMax, CoordMin, -24'sd1);
    send_vertex(CoordMin, CoordMax, 24'sd1);
    random_vertices(150);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    random_vertices(150);

    for (int p = 0; p < 8; p++) begin
      apply_setting(any_angle(), any_angle(), any_angle(),
                    any_coord(), any_coord(), any_coord());
      random_vertices(190);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Rotated %0d vertices (%0d words back) over %0d register settings.",
             vertices_in, vertices_out, settings_done);
    $display("Covered bypassed, quarter, half and near-full turns with extreme pivots.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
